// File: hdl/okrt_pkg.sv
// ----------------------------------------------------------------------------
// okrt_pkg
// Types and codes shared by the ordered keyed record table.
// ----------------------------------------------------------------------------
`default_nettype none

package okrt_pkg;

	// request codes
	localparam logic [2:0] REQ_INSERT = 3'd0;
	localparam logic [2:0] REQ_DELETE = 3'd1;
	localparam logic [2:0] REQ_SEARCH = 3'd2;
	localparam logic [2:0] REQ_LIST   = 3'd3;
	localparam logic [2:0] REQ_CLEAR  = 3'd4;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_EMPTY    = 2'd1;
	localparam logic [1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [1:0] STAT_FULL     = 2'd3;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] key_id;
		logic [7:0]         age_value;
	} req_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] out_key;
		logic [7:0]         out_age;
		logic               last;
	} rsp_word_t;

	// one stored record
	typedef struct packed {
		logic signed [31:0] key;
		logic [7:0]         age;
	} rec_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_LIST,
		S_RESP
	} state_t;

endpackage

`default_nettype wire

// File: hdl/ordered_keyed_record_table.sv
// ----------------------------------------------------------------------------
// ordered_keyed_record_table
// Bounded table of (key, age) records kept in insertion order.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid / req_stall / req) carries one request word:
//    insert, delete, search, list all, clear. Codes 5..7 are dropped.
//  - rsp channel (rsp_valid / rsp_stall / rsp) returns result words; the
//    final word of each request has last set. List gives one word per record.
//  - Records live in a single-port-write, single-port-read RAM with a
//    registered read. A small sequencer walks it one entry per cycle unless stalled.
//  - Flow: insert, clear and empty answers go straight to the answer state;
//    search and delete scan from the head until a match or the last entry;
//    delete then closes the gap by moving each later entry down one place.
//    List loads one word per cycle unless rsp_stall holds. The next request is
//    taken the cycle after the final word loads, so inserts are not back to back.
//  - req_stall is high while a request is in progress; a new request is taken
//    in idle even while the previous answer still waits in the output register.
//  - rsp_stall holds the output word; a list walk pauses with it.
//  - Reset empties the table (entry count to zero); RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_keyed_record_table #(
	parameter int CAPACITY = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire okrt_pkg::req_word_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output okrt_pkg::rsp_word_t      rsp
);
	import okrt_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// record RAM
	rec_t mem [CAPACITY];

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;   // number of valid records
	logic [CNT_W-1:0]   ptr_q, ptr_d;       // next RAM read address
	logic [2:0]         op_q, op_d;
	logic signed [31:0] key_q, key_d;
	rsp_word_t          res_q, res_d;       // pending single answer
	rsp_word_t          rsp_q, out_d;
	logic               rsp_valid_q;

	// read stage
	logic               rd_vld_s1;
	logic [CNT_W-1:0]   rd_idx_s1;
	rec_t               rd_rec_s1;

	logic               issue;
	logic               rd_take;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	rec_t               wdata;
	logic               out_load;
	logic               load_ok;
	logic               match;
	logic               rd_last;
	logic [CNT_W-1:0]   idx_m1;
	logic [CNT_W-1:0]   count_m1;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		ptr_d    = ptr_q;
		op_d     = op_q;
		key_d    = key_q;
		res_d    = res_q;
		out_d    = rsp_q;
		issue    = 1'b0;
		rd_take  = 1'b0;
		we       = 1'b0;
		waddr    = '0;
		wdata    = '0;
		out_load = 1'b0;
		load_ok  = !rsp_valid_q || !rsp_stall;
		match    = rd_vld_s1 && (rd_rec_s1.key == key_q);
		count_m1 = count_q - CNT_W'(1);
		idx_m1   = rd_idx_s1 - CNT_W'(1);
		rd_last  = (rd_idx_s1 == count_m1);

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					key_d = req.key_id;
					op_d  = req.req_type;
					ptr_d = '0;
					case (req.req_type)
						REQ_INSERT: begin
							if (count_q == CNT_W'(CAPACITY)) begin
								res_d = '{status: STAT_FULL, out_key: '0, out_age: '0,
									last: 1'b1};
							end else begin
								we      = 1'b1;
								waddr   = count_q[IDX_W-1:0];
								wdata   = '{key: req.key_id, age: req.age_value};
								count_d = count_q + CNT_W'(1);
								res_d   = '{status: STAT_OK, out_key: '0, out_age: '0,
									last: 1'b1};
							end
							state_d = S_RESP;
						end
						REQ_DELETE, REQ_SEARCH: begin
							if (count_q == '0) begin
								res_d = '{status: STAT_EMPTY, out_key: '0, out_age: '0,
									last: 1'b1};
								state_d = S_RESP;
							end else begin
								state_d = S_SCAN;
							end
						end
						REQ_LIST: begin
							if (count_q == '0) begin
								res_d = '{status: STAT_EMPTY, out_key: '0, out_age: '0,
									last: 1'b1};
								state_d = S_RESP;
							end else begin
								state_d = S_LIST;
							end
						end
						REQ_CLEAR: begin
							count_d = '0;
							res_d   = '{status: STAT_OK, out_key: '0, out_age: '0,
								last: 1'b1};
							state_d = S_RESP;
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				rd_take = rd_vld_s1;
				issue   = (ptr_q < count_q) && !match;
				if (issue) begin
					ptr_d = ptr_q + CNT_W'(1);
				end
				if (match) begin
					if (op_q == REQ_DELETE) begin
						ptr_d   = rd_idx_s1 + CNT_W'(1);
						state_d = S_SHIFT;
					end else begin
						res_d = '{status: STAT_OK, out_key: rd_rec_s1.key,
							out_age: rd_rec_s1.age, last: 1'b1};
						state_d = S_RESP;
					end
				end else if (rd_vld_s1 && rd_last) begin
					res_d = '{status: STAT_NOTFOUND, out_key: '0, out_age: '0,
						last: 1'b1};
					state_d = S_RESP;
				end
			end
			S_SHIFT: begin
				// read entry i, write it back at i-1
				rd_take = rd_vld_s1;
				issue   = (ptr_q < count_q);
				if (issue) begin
					ptr_d = ptr_q + CNT_W'(1);
				end
				if (rd_vld_s1) begin
					we    = 1'b1;
					waddr = idx_m1[IDX_W-1:0];
					wdata = rd_rec_s1;
				end
				if (!issue && !rd_vld_s1) begin
					count_d = count_m1;
					res_d   = '{status: STAT_OK, out_key: '0, out_age: '0, last: 1'b1};
					state_d = S_RESP;
				end
			end
			S_LIST: begin
				rd_take = rd_vld_s1 && load_ok;
				issue   = (ptr_q < count_q) && (!rd_vld_s1 || load_ok);
				if (issue) begin
					ptr_d = ptr_q + CNT_W'(1);
				end
				if (rd_take) begin
					out_load = 1'b1;
					out_d    = '{status: STAT_OK, out_key: rd_rec_s1.key,
						out_age: rd_rec_s1.age, last: rd_last};
					if (rd_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_RESP: begin
				if (load_ok) begin
					out_load = 1'b1;
					out_d    = res_q;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			ptr_q       <= ptr_d;
			rd_vld_s1   <= issue || (rd_vld_s1 && !rd_take);
			rsp_valid_q <= out_load || (rsp_valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		op_q  <= op_d;
		key_q <= key_d;
		res_q <= res_d;
		if (out_load) begin
			rsp_q <= out_d;
		end
		if (issue) begin
			rd_idx_s1 <= ptr_q;
		end
	end

	// RAM: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (issue) begin
			rd_rec_s1 <= mem[ptr_q[IDX_W-1:0]];
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN || state_q == S_SHIFT || state_q == S_LIST))
		else $error("read data pending outside a table walk");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && req.req_type == REQ_INSERT
			&& count_q != CNT_W'(CAPACITY))
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the table");

	a_list_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == S_LIST && state_q == S_IDLE) |-> (rsp_valid_q && rsp_q.last))
		else $error("list walk ended without a last word");
`endif

endmodule

`default_nettype wire

// File: tb/record_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_table_checker
// Watches both channels of the record table. It keeps its own copy of the
// table, predicts every answer word and checks the words field by field.
// ----------------------------------------------------------------------------

module record_table_checker #(
	parameter int CAPACITY = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  okrt_pkg::req_word_t req,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  okrt_pkg::rsp_word_t rsp,
	output int                  fail_count,
	output int                  pending
);
	import okrt_pkg::*;

	logic signed [31:0] tab_key [CAPACITY];
	logic [7:0]         tab_age [CAPACITY];
	int                 tab_fill;
	rsp_word_t          answer_q [$];

	function automatic rsp_word_t answer(input logic [1:0] st, input logic signed [31:0] k,
			input logic [7:0] a, input logic l);
		rsp_word_t w;
		w.status  = st;
		w.out_key = k;
		w.out_age = a;
		w.last    = l;
		return w;
	endfunction

	// update the table copy and queue the answer words of one request
	task automatic apply_request(input req_word_t w);
		int hit;
		hit = -1;
		for (int i = 0; i < tab_fill; i++)
			if (hit < 0 && tab_key[i] == w.key_id)
				hit = i;
		case (w.req_type)
			REQ_INSERT: begin
				if (tab_fill >= CAPACITY) begin
					answer_q.push_back(answer(STAT_FULL, '0, '0, 1'b1));
				end else begin
					tab_key[tab_fill] = w.key_id;
					tab_age[tab_fill] = w.age_value;
					tab_fill++;
					answer_q.push_back(answer(STAT_OK, '0, '0, 1'b1));
				end
			end
			REQ_DELETE: begin
				if (tab_fill == 0) begin
					answer_q.push_back(answer(STAT_EMPTY, '0, '0, 1'b1));
				end else if (hit < 0) begin
					answer_q.push_back(answer(STAT_NOTFOUND, '0, '0, 1'b1));
				end else begin
					for (int i = hit; i < tab_fill - 1; i++) begin
						tab_key[i] = tab_key[i + 1];
						tab_age[i] = tab_age[i + 1];
					end
					tab_fill--;
					answer_q.push_back(answer(STAT_OK, '0, '0, 1'b1));
				end
			end
			REQ_SEARCH: begin
				if (tab_fill == 0)
					answer_q.push_back(answer(STAT_EMPTY, '0, '0, 1'b1));
				else if (hit < 0)
					answer_q.push_back(answer(STAT_NOTFOUND, '0, '0, 1'b1));
				else
					answer_q.push_back(answer(STAT_OK, tab_key[hit], tab_age[hit], 1'b1));
			end
			REQ_LIST: begin
				if (tab_fill == 0)
					answer_q.push_back(answer(STAT_EMPTY, '0, '0, 1'b1));
				for (int i = 0; i < tab_fill; i++)
					answer_q.push_back(answer(STAT_OK, tab_key[i], tab_age[i],
						i == tab_fill - 1));
			end
			REQ_CLEAR: begin
				tab_fill = 0;
				answer_q.push_back(answer(STAT_OK, '0, '0, 1'b1));
			end
			default: begin
				// spare codes are dropped without an answer
			end
		endcase
	endtask

	task automatic note_fail(input string what, input rsp_word_t want, input rsp_word_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t %s: exp st=%0d key=%h age=%h last=%b, got st=%0d key=%h age=%h last=%b",
				$realtime, what, want.status, want.out_key, want.out_age, want.last,
				got.status, got.out_key, got.out_age, got.last);
	endtask

	task automatic check_word(input rsp_word_t got);
		rsp_word_t want;
		if (answer_q.size() == 0) begin
			note_fail("answer word with none due", '0, got);
		end else begin
			want = answer_q.pop_front();
			if (got.status !== want.status || got.out_key !== want.out_key ||
					got.out_age !== want.out_age || got.last !== want.last)
				note_fail("answer word mismatch", want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_fill = 0;
			answer_q.delete();
			fail_count = 0;
		end else begin
			// answers always come after their request is taken, so check first
			if (rsp_valid && !rsp_stall)
				check_word(rsp);
			if (req_valid && !req_stall)
				apply_request(req);
		end
		pending = answer_q.size();
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives request words into the ordered keyed record table and drains its
// answer words, both sides with random gaps. A directed opening covers the
// corner cases; random phases then alternate between filling the table up
// to full and draining it. The checker beside the block does the predicting.
// ----------------------------------------------------------------------------

module testbench;
	import okrt_pkg::*;

	localparam int CAPACITY     = 32;
	localparam int RANDOM_ITEMS = 200;   // answered requests in the random part
	localparam int PHASE_ITEMS  = 50;    // answered requests per fill/drain phase
	localparam int QUIET_LIMIT  = 2000;  // cycles without any word moving
	localparam int DRAIN_CYCLES = 64;    // > worst delete scan + shift

	// codes the block must drop silently
	localparam logic [2:0] REQ_RSVD_5 = 3'd5;
	localparam logic [2:0] REQ_RSVD_6 = 3'd6;
	localparam logic [2:0] REQ_RSVD_7 = 3'd7;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	int fail_count;
	int pending;
	int quiet_cycles = 0;
	bit idling_on    = 1'b1;   // cleared for one phase: back-to-back words

	// small key pool so searches and deletes hit; extremes included
	logic signed [31:0] key_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
		32'h7FFF_FFFF, 32'h0000_0001, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0000_002A};

	ordered_keyed_record_table #(.CAPACITY(CAPACITY)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	record_table_checker #(.CAPACITY(CAPACITY)) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// watchdog: a hang shows up as a long stretch with no word accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// One request word: optional gap with valid low, then hold the word until
	// the block takes it. With no gap valid just stays high for the next word.
	task automatic send_word(input logic [2:0] kind, input logic signed [31:0] key,
			input logic [7:0] age);
		int gap;
		req_word_t w;
		gap = idling_on ? $urandom_range(4, 0) : 0;
		w.req_type  = kind;
		w.key_id    = key;
		w.age_value = age;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		// stall sampled at the edge is the pre-edge value, i.e. the one that counts
		do @(posedge clk); while (req_stall);
	endtask

	// Random request. Filling phases lean on inserts so the table reaches full,
	// draining phases lean on deletes so it runs back down to empty.
	task automatic send_random(input bit filling, output bit answered);
		int roll;
		logic [2:0] kind;
		logic signed [31:0] key;
		roll = $urandom_range(99, 0);
		if (filling)
			kind = roll < 78 ? REQ_INSERT : roll < 86 ? REQ_DELETE :
				roll < 93 ? REQ_SEARCH : roll < 97 ? REQ_LIST : REQ_RSVD_5;
		else
			kind = roll < 15 ? REQ_INSERT : roll < 60 ? REQ_DELETE :
				roll < 82 ? REQ_SEARCH : roll < 94 ? REQ_LIST :
				roll < 97 ? REQ_CLEAR : REQ_RSVD_5;
		if (kind == REQ_RSVD_5) begin
			case ($urandom_range(2, 0))
				0: kind = REQ_RSVD_5;
				1: kind = REQ_RSVD_6;
				default: kind = REQ_RSVD_7;
			endcase
		end
		// a quarter of the keys are fully random: misses and all key bits
		key = ($urandom_range(3, 0) == 0) ? $urandom : key_pool[$urandom_range(7, 0)];
		answered = (kind <= REQ_CLEAR);
		send_word(kind, key, 8'($urandom_range(255, 0)));
	endtask

	// answer side: draw a stall per word, then take whatever comes
	initial begin : answer_sink
		int hold;
		@(posedge arst_n);
		forever begin
			hold = idling_on ? $urandom_range(4, 0) : 0;
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			do @(posedge clk); while (!rsp_valid);
		end
	end

	initial begin : stimulus
		int taken;
		bit answered;
		taken = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty-table answers; clear on an empty table still says ok
		send_word(REQ_LIST,   32'h0000_0000, 8'h00);
		send_word(REQ_SEARCH, 32'h7FFF_FFFF, 8'h00);
		send_word(REQ_DELETE, 32'h8000_0000, 8'h00);
		send_word(REQ_CLEAR,  32'h0000_0000, 8'h00);
		// extreme keys and ages, plus a duplicate key
		send_word(REQ_INSERT, 32'h8000_0000, 8'h00);
		send_word(REQ_INSERT, 32'h7FFF_FFFF, 8'hFF);
		send_word(REQ_INSERT, 32'hFFFF_FFFF, 8'hAA);
		send_word(REQ_INSERT, 32'h0000_0000, 8'h55);
		send_word(REQ_INSERT, 32'h7FFF_FFFF, 8'h01);
		// first match wins; misses give not found
		send_word(REQ_SEARCH, 32'h7FFF_FFFF, 8'h00);
		send_word(REQ_SEARCH, 32'h1234_5678, 8'h00);
		send_word(REQ_DELETE, 32'h0000_0001, 8'h00);
		send_word(REQ_LIST,   32'h0000_0000, 8'h00);
		// delete from the middle, then head, then middle again; the duplicate surfaces
		send_word(REQ_DELETE, 32'h7FFF_FFFF, 8'h00);
		send_word(REQ_SEARCH, 32'h7FFF_FFFF, 8'h00);
		send_word(REQ_DELETE, 32'h8000_0000, 8'h00);
		send_word(REQ_DELETE, 32'h0000_0000, 8'h00);
		// spare codes: no answer, no change
		send_word(REQ_RSVD_5, 32'hFFFF_FFFF, 8'hFF);
		send_word(REQ_RSVD_6, 32'h7FFF_FFFF, 8'hFF);
		send_word(REQ_RSVD_7, 32'hFFFF_FFFF, 8'hFF);
		send_word(REQ_LIST,   32'h0000_0000, 8'h00);
		send_word(REQ_CLEAR,  32'h0000_0000, 8'h00);
		send_word(REQ_LIST,   32'h0000_0000, 8'h00);

		// fill, drain, fill without gaps, drain
		while (taken < RANDOM_ITEMS) begin
			idling_on = (taken / PHASE_ITEMS) != 2;
			send_random(((taken / PHASE_ITEMS) % 2) == 0, answered);
			if (answered)
				taken++;
		end
		req_valid <= 1'b0;
		idling_on = 1'b1;

		// let the checker take the last word in, then wait out the answers
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: filelist.f
hdl/okrt_pkg.sv
hdl/ordered_keyed_record_table.sv
tb/record_table_checker.sv
tb/testbench.sv
